FILE: rtl/hns_pkg.sv
package hns_pkg;

   // register file
   localparam int IMG_W_BITS = 11;
   localparam int IMG_H_BITS = 13;
   localparam int CSR_DATA_W = 13;
   localparam logic [IMG_W_BITS-1:0] WIDTH_RESET  = 11'd256;
   localparam logic [IMG_H_BITS-1:0] HEIGHT_RESET = 13'd256;
   localparam logic [IMG_H_BITS-1:0] ROW_LIMIT    = 13'd4096;

   typedef logic [0:0] csr_index_type;
   localparam csr_index_type CSR_IMAGE_WIDTH  = 1'b0;
   localparam csr_index_type CSR_IMAGE_HEIGHT = 1'b1;

   // item opcodes
   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_DRAIN  = 1'b1;

   // field and datapath widths
   localparam int HEIGHT_W = 8;
   localparam int COL_W    = 10;
   localparam int ROW_W    = 12;
   localparam int NX_W     = 16;
   localparam int NY_W     = 15;
   localparam int GRAD_W   = 10;
   localparam int SQ_W     = 18;
   localparam int LEN_W    = 20;
   localparam int WIDE_W   = 32;
   localparam logic [LEN_W-1:0] NUM_Y = 20'd4;

   typedef logic [1:0] bank_type;

   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [ROW_W-1:0] row;
      logic             last;
      logic             neg_x;
      logic             neg_z;
   } meta_type;

   typedef struct packed {
      logic [NX_W-1:0]  normal_x;
      logic [NY_W-1:0]  normal_y;
      logic [NX_W-1:0]  normal_z;
      logic [COL_W-1:0] column;
      logic [ROW_W-1:0] row;
      logic             frame_last;
   } result_type;

   function automatic bank_type inc3(input bank_type b);
      return (b == 2'd2) ? 2'd0 : bank_type'(b + 2'd1);
   endfunction

   function automatic bank_type dec3(input bank_type b);
      return (b == 2'd0) ? 2'd2 : bank_type'(b - 2'd1);
   endfunction

   // 4 is 1 mod 3, so the 2-bit digits just add up
   function automatic bank_type mod3_12(input logic [ROW_W-1:0] v);
      logic [4:0] s;
      logic [2:0] t;
      logic [2:0] u;
      s = '0;
      for (int i = 0; i < 6; i++) s = s + 5'(v[2*i +: 2]);
      t = 3'(s[4:2]) + 3'(s[1:0]);
      u = 3'(t[2]) + 3'(t[1:0]);
      return (u >= 3'd3) ? bank_type'(u - 3'd3) : bank_type'(u);
   endfunction

   // divider steps, root steps and the rounding register
   function automatic int lane_latency(input int frac);
      return 3 * frac + 4;
   endfunction

endpackage

FILE: rtl/hns_req_if.sv
interface hns_req_if;
   import hns_pkg::*;

   logic                valid;
   logic                ready;
   logic                opcode;
   logic [HEIGHT_W-1:0] height_sample;

   modport source (output valid, output opcode, output height_sample, input ready);
   modport sink   (input valid, input opcode, input height_sample, output ready);
endinterface

FILE: rtl/hns_rsp_if.sv
interface hns_rsp_if;
   import hns_pkg::*;

   logic                    valid;
   logic                    ready;
   logic signed [NX_W-1:0]  normal_x;
   logic [NY_W-1:0]         normal_y;
   logic signed [NX_W-1:0]  normal_z;
   logic [COL_W-1:0]        column;
   logic [ROW_W-1:0]        row;
   logic                    frame_last;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   output column, output row, output frame_last, input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   input column, input row, input frame_last, output ready);
endinterface

FILE: rtl/hns_line_store.sv
module hns_line_store #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  hns_pkg::bank_type                wr_bank,
   input  logic [$clog2(MAX_WIDTH)-1:0]     wr_addr,
   input  logic [hns_pkg::HEIGHT_W-1:0]     wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr_l,
   input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr_c,
   input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr_r,
   output logic [2:0][hns_pkg::HEIGHT_W-1:0] rd_left,
   output logic [2:0][hns_pkg::HEIGHT_W-1:0] rd_center,
   output logic [2:0][hns_pkg::HEIGHT_W-1:0] rd_right
);
   import hns_pkg::*;

   logic [HEIGHT_W-1:0] rd_left_ff   [3];
   logic [HEIGHT_W-1:0] rd_center_ff [3];
   logic [HEIGHT_W-1:0] rd_right_ff  [3];

   // one bank per row mod 3, each kept twice for a third read port
   for (genvar k = 0; k < 3; k++) begin : g_bank
      logic [HEIGHT_W-1:0] mem_a [MAX_WIDTH];
      logic [HEIGHT_W-1:0] mem_b [MAX_WIDTH];

      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == bank_type'(k)) begin
            mem_a[wr_addr] <= wr_data;
            mem_b[wr_addr] <= wr_data;
         end
         if (rd_en) begin
            rd_left_ff[k]   <= mem_a[rd_addr_l];
            rd_center_ff[k] <= mem_a[rd_addr_c];
            rd_right_ff[k]  <= mem_b[rd_addr_r];
         end
      end
   end

   assign rd_left   = {rd_left_ff[2], rd_left_ff[1], rd_left_ff[0]};
   assign rd_center = {rd_center_ff[2], rd_center_ff[1], rd_center_ff[0]};
   assign rd_right  = {rd_right_ff[2], rd_right_ff[1], rd_right_ff[0]};
endmodule

FILE: rtl/hns_ratio_lane.sv
module hns_ratio_lane #(
   parameter int FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        advance,
   input  logic [hns_pkg::LEN_W-1:0]   num,
   input  logic [hns_pkg::LEN_W-1:0]   den,
   output logic [FRAC_BITS:0]          ratio
);
   import hns_pkg::*;

   localparam int DS = 2 * FRAC_BITS + 2;
   localparam int QW = DS;
   localparam int SS = FRAC_BITS + 1;

   logic [LEN_W-1:0] rem_ff [DS-1];
   logic [LEN_W-1:0] den_ff [DS-1];
   logic [QW-1:0]    quo_ff [DS];
   logic [QW-1:0]    n_ff   [SS-1];
   logic [QW-1:0]    res_ff [SS];
   logic [FRAC_BITS:0] ratio_ff;
   logic [FRAC_BITS+1:0] round_in;

   // restoring division num * 2^DS / den, one quotient bit per stage
   for (genvar k = 0; k < DS; k++) begin : g_div
      logic [LEN_W-1:0] rem_prev;
      logic [LEN_W-1:0] den_prev;
      logic [QW-1:0]    quo_prev;
      logic [LEN_W:0]   trial;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_prev = num;
         assign den_prev = den;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      assign trial = {rem_prev, 1'b0};
      assign take  = trial >= {1'b0, den_prev};

      always_ff @(posedge clock) begin
         if (advance) quo_ff[k] <= {quo_prev[QW-2:0], take};
      end

      if (k < DS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) begin
               rem_ff[k] <= take ? LEN_W'(trial - {1'b0, den_prev}) : trial[LEN_W-1:0];
               den_ff[k] <= den_prev;
            end
         end
      end
   end

   // digit-by-digit square root of the quotient, one result bit per stage
   for (genvar j = 0; j < SS; j++) begin : g_sqrt
      localparam int B = 2 * (FRAC_BITS - j);
      logic [QW-1:0] n_prev;
      logic [QW-1:0] res_prev;
      logic [QW-1:0] bit_val;
      logic [QW-1:0] sum;
      logic          ge;

      if (j == 0) begin : g_first
         assign n_prev   = quo_ff[DS-1];
         assign res_prev = '0;
      end else begin : g_next
         assign n_prev   = n_ff[j-1];
         assign res_prev = res_ff[j-1];
      end

      assign bit_val = QW'(1) << B;
      assign sum     = res_prev + bit_val;
      assign ge      = n_prev >= sum;

      always_ff @(posedge clock) begin
         if (advance) res_ff[j] <= ge ? (res_prev >> 1) + bit_val : res_prev >> 1;
      end

      if (j < SS - 1) begin : g_carry
         always_ff @(posedge clock) begin
            if (advance) n_ff[j] <= ge ? n_prev - sum : n_prev;
         end
      end
   end

   // halve with rounding
   assign round_in = {1'b0, res_ff[SS-1][FRAC_BITS:0]} + (FRAC_BITS+2)'(1);

   always_ff @(posedge clock) begin
      if (advance) ratio_ff <= round_in[FRAC_BITS+1:1];
   end

   assign ratio = ratio_ff;
endmodule

FILE: rtl/heightmap_normal_stencil.sv
// heightmap normal stencil
// req_ch takes one item per transfer: opcode sample carries an 8-bit height in
// raster order, opcode drain flushes one normal of the last row (drain column
// walks left to right and wraps, frame_last marks the last column).
// rsp_ch returns the unit normal (-gx, 2, gz) normalized, each component rounded
// to NORMAL_FRAC_BITS fraction bits, with the column and row it belongs to.
// a sample of row r yields the normal of row r-1; samples of row 0 yield nothing.
// csr_*: a write of image_width (index 0) or image_height (index 1) takes effect
// at once; write only while no result is pending.
// a result passes the line store read, gradient, square, length, divider,
// square root and rounding stages and the output register, in that order.
// throughput: one item per cycle while the skid is empty, fully pipelined; the
// line store has three row banks of three read ports, one access per item.
// reset clears counters, config (256 x 256) and all valid bits; the line store
// holds no reset and needs none.
// when rsp_ch stalls, a skid register catches the one result in flight and
// the whole pipeline then holds; req_ch.ready drops until the skid empties.
module heightmap_normal_stencil #(
   parameter int MAX_WIDTH        = 1024,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  logic                        clock,
   input  logic                        reset,
   hns_req_if.sink                     req_ch,
   hns_rsp_if.source                   rsp_ch,
   input  logic                        csr_wr_en,
   input  hns_pkg::csr_index_type      csr_index,
   input  logic [hns_pkg::CSR_DATA_W-1:0] csr_wr_data
);
   import hns_pkg::*;

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int CMP_W = (WW > IMG_W_BITS) ? WW : IMG_W_BITS;
   localparam int F     = NORMAL_FRAC_BITS;
   localparam int LAT   = lane_latency(NORMAL_FRAC_BITS);

   // config registers
   logic [IMG_W_BITS-1:0] width_ff;
   logic [IMG_H_BITS-1:0] height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:  width_ff  <= csr_wr_data[IMG_W_BITS-1:0];
            CSR_IMAGE_HEIGHT: height_ff <= csr_wr_data;
         endcase
      end
   end

   // clamp out-of-range settings
   logic [WW-1:0]         width_eff;
   logic [IMG_H_BITS-1:0] height_eff;

   always_comb begin
      if (width_ff == '0) width_eff = WW'(1);
      else if (CMP_W'(width_ff) > CMP_W'(MAX_WIDTH)) width_eff = WW'(MAX_WIDTH);
      else width_eff = WW'(width_ff);
      if (height_ff == '0) height_eff = IMG_H_BITS'(1);
      else if (height_ff > ROW_LIMIT) height_eff = ROW_LIMIT;
      else height_eff = height_ff;
   end

   // global pipeline enable, dropped only while the skid register is full
   logic skid_valid_ff;
   logic advance;
   logic accept;

   assign advance      = !skid_valid_ff;
   assign req_ch.ready = advance;
   assign accept       = req_ch.valid && advance;

   // raster counters
   logic [AW-1:0]    in_col_ff, in_col_in;
   logic [ROW_W-1:0] in_row_ff, in_row_in;
   bank_type         in_bank_ff, in_bank_in;
   logic [AW-1:0]    drain_col_ff, drain_col_in;

   logic             col_wrap, row_wrap, is_drain, at_left, at_right;
   logic [AW-1:0]    col_now, drain_now, sel_col, col_left, col_right;
   logic [ROW_W:0]   row_step, row_next;
   logic [ROW_W-1:0] row_now, row_last;
   bank_type         bank_step, bank_now;
   logic [WW-1:0]    col_plus;
   bank_type         mid_bank, up_bank;

   always_comb begin
      // counters left past a new bound by a config write wrap first
      col_wrap  = WW'(in_col_ff) >= width_eff;
      col_now   = col_wrap ? '0 : in_col_ff;
      row_step  = {1'b0, in_row_ff} + (ROW_W+1)'(col_wrap);
      bank_step = col_wrap ? inc3(in_bank_ff) : in_bank_ff;
      row_wrap  = row_step >= height_eff;
      row_now   = row_wrap ? '0 : row_step[ROW_W-1:0];
      bank_now  = row_wrap ? 2'd0 : bank_step;
      drain_now = (WW'(drain_col_ff) >= width_eff) ? '0 : drain_col_ff;
      row_last  = ROW_W'(height_eff - IMG_H_BITS'(1));

      is_drain  = req_ch.opcode == OP_DRAIN;
      sel_col   = is_drain ? drain_now : col_now;
      col_plus  = WW'(sel_col) + WW'(1);
      at_left   = sel_col == '0;
      at_right  = col_plus == width_eff;
      col_left  = at_left ? sel_col : sel_col - AW'(1);
      col_right = at_right ? sel_col : col_plus[AW-1:0];

      // row banks: a drain looks at the last row, a sample at the row before it
      if (is_drain) begin
         mid_bank = mod3_12(row_last);
         up_bank  = (row_last == '0) ? mid_bank : dec3(mid_bank);
      end else begin
         mid_bank = dec3(bank_now);
         up_bank  = (row_now == ROW_W'(1)) ? mid_bank : inc3(bank_now);
      end

      row_next     = {1'b0, row_now} + (ROW_W+1)'(1);
      in_col_in    = col_now;
      in_row_in    = row_now;
      in_bank_in   = bank_now;
      drain_col_in = drain_now;
      if (is_drain) begin
         drain_col_in = at_right ? '0 : col_plus[AW-1:0];
      end else if (at_right) begin
         in_col_in = '0;
         if (row_next >= (ROW_W+1)'(height_eff)) begin
            in_row_in  = '0;
            in_bank_in = 2'd0;
         end else begin
            in_row_in  = row_next[ROW_W-1:0];
            in_bank_in = inc3(bank_now);
         end
      end else begin
         in_col_in = col_plus[AW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         in_bank_ff   <= 2'd0;
         drain_col_ff <= '0;
      end else if (accept) begin
         in_col_ff    <= in_col_in;
         in_row_ff    <= in_row_in;
         in_bank_ff   <= in_bank_in;
         drain_col_ff <= drain_col_in;
      end
   end

   // line store: write and all reads happen at the transfer edge
   logic [2:0][HEIGHT_W-1:0] rd_left, rd_center, rd_right;

   hns_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_line_store (
      .clock     (clock),
      .wr_en     (accept && !is_drain),
      .wr_bank   (bank_now),
      .wr_addr   (col_now),
      .wr_data   (req_ch.height_sample),
      .rd_en     (accept),
      .rd_addr_l (col_left),
      .rd_addr_c (sel_col),
      .rd_addr_r (col_right),
      .rd_left   (rd_left),
      .rd_center (rd_center),
      .rd_right  (rd_right)
   );

   // stage 1: item context alongside the line store read data
   logic                s1_valid_ff, s1_drain_ff, s1_dx_ff, s1_dz_ff;
   logic [HEIGHT_W-1:0] s1_sample_ff;
   bank_type            s1_mid_ff, s1_up_ff;
   meta_type            s1_meta_ff, s1_meta_in;

   always_comb begin
      s1_meta_in.col   = COL_W'(sel_col);
      s1_meta_in.row   = is_drain ? row_last : row_now - ROW_W'(1);
      s1_meta_in.last  = is_drain && at_right;
      s1_meta_in.neg_x = 1'b0;
      s1_meta_in.neg_z = 1'b0;
   end

   // stage 2: gradients
   logic                     s2_valid_ff;
   logic signed [GRAD_W-1:0] s2_gx_ff, s2_gz_ff, gx_in, gz_in;
   meta_type                 s2_meta_ff;
   logic [HEIGHT_W-1:0]      mid_l, mid_c, mid_r, up_c, down_c;

   always_comb begin
      mid_l  = rd_left[s1_mid_ff];
      mid_c  = rd_center[s1_mid_ff];
      mid_r  = rd_right[s1_mid_ff];
      up_c   = rd_center[s1_up_ff];
      down_c = s1_drain_ff ? mid_c : s1_sample_ff;
      gx_in  = $signed(GRAD_W'(mid_r)) - $signed(GRAD_W'(mid_l));
      gz_in  = $signed(GRAD_W'(down_c)) - $signed(GRAD_W'(up_c));
      // one-sided differences at the borders count double
      if (s1_dx_ff) gx_in = gx_in <<< 1;
      if (s1_dz_ff) gz_in = gz_in <<< 1;
   end

   // stage 3: squares
   logic                       s3_valid_ff;
   logic [SQ_W-1:0]            s3_sqx_ff, s3_sqz_ff;
   meta_type                   s3_meta_ff, s3_meta_in;
   logic signed [2*GRAD_W-1:0] prod_x, prod_z;

   always_comb begin
      prod_x           = s2_gx_ff * s2_gx_ff;
      prod_z           = s2_gz_ff * s2_gz_ff;
      s3_meta_in       = s2_meta_ff;
      s3_meta_in.neg_x = s2_gx_ff > 0;
      s3_meta_in.neg_z = s2_gz_ff < 0;
   end

   // stage 4: squared length
   logic             s4_valid_ff;
   logic [LEN_W-1:0] s4_len_ff, s4_numx_ff, s4_numz_ff;
   meta_type         s4_meta_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_drain_ff  <= is_drain;
         s1_sample_ff <= req_ch.height_sample;
         s1_mid_ff    <= mid_bank;
         s1_up_ff     <= up_bank;
         s1_dx_ff     <= at_left || at_right;
         s1_dz_ff     <= is_drain || row_now == ROW_W'(1);
         s1_meta_ff   <= s1_meta_in;
         s2_gx_ff     <= gx_in;
         s2_gz_ff     <= gz_in;
         s2_meta_ff   <= s1_meta_ff;
         s3_sqx_ff    <= prod_x[SQ_W-1:0];
         s3_sqz_ff    <= prod_z[SQ_W-1:0];
         s3_meta_ff   <= s3_meta_in;
         s4_len_ff    <= LEN_W'(s3_sqx_ff) + LEN_W'(s3_sqz_ff) + NUM_Y;
         s4_numx_ff   <= LEN_W'(s3_sqx_ff);
         s4_numz_ff   <= LEN_W'(s3_sqz_ff);
         s4_meta_ff   <= s3_meta_ff;
      end
   end

   // valid bits: row 0 samples carry no result
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && (is_drain || row_now != '0);
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // three ratio lanes: |gx|, 2 and |gz| over the length
   logic [F:0] ratio_x, ratio_y, ratio_z;

   hns_ratio_lane #(.FRAC_BITS(F)) u_lane_x (
      .clock(clock), .advance(advance), .num(s4_numx_ff), .den(s4_len_ff), .ratio(ratio_x)
   );
   hns_ratio_lane #(.FRAC_BITS(F)) u_lane_y (
      .clock(clock), .advance(advance), .num(NUM_Y), .den(s4_len_ff), .ratio(ratio_y)
   );
   hns_ratio_lane #(.FRAC_BITS(F)) u_lane_z (
      .clock(clock), .advance(advance), .num(s4_numz_ff), .den(s4_len_ff), .ratio(ratio_z)
   );

   // context travels beside the lanes
   meta_type meta_ff  [LAT];
   logic     valid_ff [LAT];

   always_ff @(posedge clock) begin
      if (advance) begin
         meta_ff[0] <= s4_meta_ff;
         for (int k = 1; k < LAT; k++) meta_ff[k] <= meta_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < LAT; k++) valid_ff[k] <= 1'b0;
      end else if (advance) begin
         valid_ff[0] <= s4_valid_ff;
         for (int k = 1; k < LAT; k++) valid_ff[k] <= valid_ff[k-1];
      end
   end

   // apply signs and cut to field widths
   result_type       result_in;
   logic [WIDE_W-1:0] ext_x, ext_y, ext_z, val_x, val_z;
   meta_type         meta_out;

   always_comb begin
      meta_out             = meta_ff[LAT-1];
      ext_x                = WIDE_W'(ratio_x);
      ext_y                = WIDE_W'(ratio_y);
      ext_z                = WIDE_W'(ratio_z);
      val_x                = meta_out.neg_x ? WIDE_W'(0) - ext_x : ext_x;
      val_z                = meta_out.neg_z ? WIDE_W'(0) - ext_z : ext_z;
      result_in.normal_x   = val_x[NX_W-1:0];
      result_in.normal_y   = ext_y[NY_W-1:0];
      result_in.normal_z   = val_z[NX_W-1:0];
      result_in.column     = meta_out.col;
      result_in.row        = meta_out.row;
      result_in.frame_last = meta_out.last;
   end

   // output register with skid
   result_type out_ff, skid_ff;
   logic       out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ch.ready) skid_valid_ff <= 1'b0;
      end else if (valid_ff[LAT-1]) begin
         if (!out_valid_ff || rsp_ch.ready) out_valid_ff <= 1'b1;
         else skid_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ch.ready) out_ff <= skid_ff;
      end else if (valid_ff[LAT-1]) begin
         if (!out_valid_ff || rsp_ch.ready) out_ff <= result_in;
         else skid_ff <= result_in;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.normal_x   = out_ff.normal_x;
   assign rsp_ch.normal_y   = out_ff.normal_y;
   assign rsp_ch.normal_z   = out_ff.normal_z;
   assign rsp_ch.column     = out_ff.column;
   assign rsp_ch.row        = out_ff.row;
   assign rsp_ch.frame_last = out_ff.frame_last;
endmodule

FILE: tb/sv/tb_heightmap_normal_stencil.sv
module tb_heightmap_normal_stencil;
   import hns_pkg::*;

   localparam int MAX_COLS   = 1024;
   localparam int FRAC       = 14;
   // long enough for a result to trail its transfer, plus a margin
   localparam int SETTLE     = 3 * FRAC + 20;
   localparam int RAND_ITEMS = 1050;

   logic clock;
   logic reset;
   logic csr_wr_en;
   csr_index_type csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   hns_req_if req_ch ();
   hns_rsp_if rsp_ch ();

   heightmap_normal_stencil #(
      .MAX_WIDTH        (MAX_COLS),
      .NORMAL_FRAC_BITS (FRAC)
   ) DUT (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // 12-unit clock
   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // expected normals, oldest first
   result_type normal_queue[$];
   int errors = 0;
   int cycle_count = 0;
   int items_sent;

   // own copy of the line store, counters and image size
   logic [HEIGHT_W-1:0] height_rows[3*MAX_COLS];
   int unsigned next_col, next_row, flush_col;
   int unsigned img_w, img_h;

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycle_count, what);
      errors++;
   endtask

   function automatic int unsigned used_width();
      if (img_w == 0) return 1;
      if (img_w > MAX_COLS) return MAX_COLS;
      return img_w;
   endfunction

   function automatic int unsigned used_height();
      if (img_h == 0) return 1;
      if (img_h > 4096) return 4096;
      return img_h;
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned n);
      longint unsigned res, bit_val;
      res = 0;
      bit_val = 64'd1 << 62;
      while (bit_val > n) bit_val >>= 2;
      while (bit_val != 0) begin
         if (n >= res + bit_val) begin
            n -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   // round(mag * 2^FRAC / sqrt(len2)) computed exactly: square it, divide, root
   function automatic longint unsigned unit_ratio(input int unsigned mag,
                                                  input int unsigned len2);
      longint unsigned rem, quo;
      rem = longint'(mag) * mag;
      quo = 0;
      for (int k = 0; k < 2 * FRAC + 2; k++) begin
         rem <<= 1;
         quo <<= 1;
         if (rem >= len2) begin
            rem -= len2;
            quo |= 1;
         end
      end
      return (int_sqrt(quo) + 1) >> 1;
   endfunction

   function automatic logic [NX_W-1:0] signed_part(input int v, input int unsigned len2);
      longint unsigned q;
      q = unit_ratio((v < 0) ? -v : v, len2);
      if (v < 0) q = -q;
      return q[NX_W-1:0];
   endfunction

   function automatic result_type stencil_normal(input int unsigned c, input int unsigned r,
                                                 input int unsigned mid, input int unsigned up,
                                                 input int unsigned down, input bit last);
      result_type res;
      int unsigned w, h, lc, rc, len2;
      int gx, gz;
      w = used_width();
      h = used_height();
      lc = (c > 0) ? c - 1 : c;
      rc = (c + 1 < w) ? c + 1 : c;
      gx = int'(height_rows[mid*MAX_COLS + rc]) - int'(height_rows[mid*MAX_COLS + lc]);
      gz = int'(height_rows[down*MAX_COLS + c]) - int'(height_rows[up*MAX_COLS + c]);
      // one-sided differences at the borders count twice
      if (c == 0 || c + 1 == w) gx *= 2;
      if (r == 0 || r + 1 == h) gz *= 2;
      len2 = gx * gx + 4 + gz * gz;
      res.normal_x   = signed_part(-gx, len2);
      res.normal_y   = NY_W'(unit_ratio(2, len2));
      res.normal_z   = signed_part(gz, len2);
      res.column     = COL_W'(c);
      res.row        = ROW_W'(r);
      res.frame_last = last;
      return res;
   endfunction

   // advance the stencil by one item; sample of row 0 gives nothing
   task automatic predict_normal(input logic op, input logic [HEIGHT_W-1:0] hgt,
                                 output bit has_normal, output result_type res);
      int unsigned w, h, c, r, pr, ur;
      bit last;
      w = used_width();
      h = used_height();
      has_normal = 1'b0;
      res = '0;
      // counters left past a new bound wrap first
      if (next_col >= w) begin
         next_col = 0;
         next_row++;
      end
      if (next_row >= h) next_row = 0;
      if (flush_col >= w) flush_col = 0;
      if (op == OP_SAMPLE) begin
         c = next_col;
         r = next_row;
         height_rows[(r % 3)*MAX_COLS + c] = hgt;
         if (r >= 1) begin
            pr = r - 1;
            ur = (pr > 0) ? pr - 1 : pr;
            res = stencil_normal(c, pr, pr % 3, ur % 3, r % 3, 1'b0);
            has_normal = 1'b1;
         end
         next_col++;
         if (next_col >= w) begin
            next_col = 0;
            next_row++;
            if (next_row >= h) next_row = 0;
         end
      end else begin
         // drain flushes the last row from whatever the store holds
         c = flush_col;
         r = h - 1;
         ur = (r > 0) ? r - 1 : r;
         last = (c + 1 == w);
         res = stencil_normal(c, r, r % 3, ur % 3, r % 3, last);
         has_normal = 1'b1;
         flush_col = last ? 0 : c + 1;
      end
   endtask

   // sender: present at falling edge, hold until the transfer
   // quiet_send suppresses idle gaps for a stretch of items
   bit quiet_send;

   task automatic send_item(input logic op, input logic [HEIGHT_W-1:0] hgt,
                            input bit typed, input result_type typed_normal);
      bit has_normal;
      result_type res;
      if (!quiet_send) begin
         while ($urandom_range(0, 99) < 9) begin
            req_ch.valid = 1'b0;
            @(negedge clock);
         end
      end
      req_ch.valid = 1'b1;
      req_ch.opcode = op;
      req_ch.height_sample = hgt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_normal(op, hgt, has_normal, res);
      if (has_normal) begin
         // flat-surface rows carry their normal typed in
         if (typed) begin
            res.normal_x = typed_normal.normal_x;
            res.normal_y = typed_normal.normal_y;
            res.normal_z = typed_normal.normal_z;
         end
         normal_queue.push_back(res);
      end
      items_sent++;
      @(negedge clock);
      req_ch.valid = 1'b0;
   endtask

   // register write only when the pipe is empty and settled
   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] value);
      req_ch.valid = 1'b0;
      while (normal_queue.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = idx;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (idx == CSR_IMAGE_WIDTH) img_w = value[IMG_W_BITS-1:0];
      else img_h = value[IMG_H_BITS-1:0];
   endtask

   // receiver: random stalls, one long hold-off, one stretch with no stalls
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (cycle_count >= 1500 && cycle_count < 1800) rsp_ch.ready = 1'b0;
         else if (cycle_count >= 5000 && cycle_count < 5800) rsp_ch.ready = 1'b1;
         else rsp_ch.ready = ($urandom_range(0, 99) >= 9);
      end
   end

   // result checker
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (normal_queue.size() == 0) begin
            report_mismatch("normal transfer with nothing expected");
         end else begin
            result_type want;
            want = normal_queue.pop_front();
            if (rsp_ch.normal_x !== want.normal_x)
               report_mismatch($sformatf("normal_x %0d want %0d", rsp_ch.normal_x,
                                         $signed(want.normal_x)));
            if (rsp_ch.normal_y !== want.normal_y)
               report_mismatch($sformatf("normal_y %0d want %0d", rsp_ch.normal_y,
                                         want.normal_y));
            if (rsp_ch.normal_z !== want.normal_z)
               report_mismatch($sformatf("normal_z %0d want %0d", rsp_ch.normal_z,
                                         $signed(want.normal_z)));
            if (rsp_ch.column !== want.column)
               report_mismatch($sformatf("column %0d want %0d", rsp_ch.column, want.column));
            if (rsp_ch.row !== want.row)
               report_mismatch($sformatf("row %0d want %0d", rsp_ch.row, want.row));
            if (rsp_ch.frame_last !== want.frame_last)
               report_mismatch($sformatf("frame_last %0b want %0b", rsp_ch.frame_last,
                                         want.frame_last));
         end
      end
   end

   // run limit
   initial begin
      #(12 * 2000000);
      $display("*** FAILED ***");
      $finish;
   end

   typedef struct {
      logic              op;
      logic [HEIGHT_W-1:0] hgt;
      bit                flat;
   } plan_row_type;

   plan_row_type plan[$];

   initial begin
      result_type flat_normal;
      result_type none;
      int unsigned w_pick, h_pick, phase_len;
      logic [CSR_DATA_W-1:0] w_odd[6];
      logic [CSR_DATA_W-1:0] h_odd[6];

      items_sent = 0;
      quiet_send = 1'b0;
      next_col = 0;
      next_row = 0;
      flush_col = 0;
      img_w = WIDTH_RESET;
      img_h = HEIGHT_RESET;
      none = '0;
      flat_normal = '0;
      flat_normal.normal_y = NY_W'(1 << FRAC);
      w_odd = '{13'd0, 13'd1, 13'd1024, 13'd1025, 13'd2047, 13'h1FFF};
      h_odd = '{13'd0, 13'd1, 13'd4096, 13'd4097, 13'd8191, 13'd2};

      req_ch.valid = 1'b0;
      req_ch.opcode = OP_SAMPLE;
      req_ch.height_sample = '0;
      csr_wr_en = 1'b0;
      csr_index = CSR_IMAGE_WIDTH;
      csr_wr_data = '0;
      reset = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill all three banks at full width so no read ever hits an unwritten entry;
      // the long receiver hold-off lands here and backs up the input
      write_reg(CSR_IMAGE_WIDTH, 13'd1024);
      write_reg(CSR_IMAGE_HEIGHT, 13'd3);
      for (int i = 0; i < 3 * MAX_COLS; i++)
         send_item(OP_SAMPLE, HEIGHT_W'($urandom_range(0, 255)), 1'b0, none);

      // directed: small 4 x 3 image
      write_reg(CSR_IMAGE_WIDTH, 13'd4);
      plan = '{
         // row 0: no normals
         '{OP_SAMPLE, 8'd100, 0}, '{OP_SAMPLE, 8'd100, 0},
         '{OP_SAMPLE, 8'd100, 0}, '{OP_SAMPLE, 8'd100, 0},
         // row 1 over a flat row 0: straight-up normals
         '{OP_SAMPLE, 8'd100, 1}, '{OP_SAMPLE, 8'd100, 1},
         '{OP_SAMPLE, 8'd100, 1}, '{OP_SAMPLE, 8'd100, 1},
         // row 2 full swing, steepest vertical differences on row 1
         '{OP_SAMPLE, 8'd0, 0},   '{OP_SAMPLE, 8'd255, 0},
         '{OP_SAMPLE, 8'd0, 0},   '{OP_SAMPLE, 8'd255, 0},
         // flush the last row, frame_last on the fourth
         '{OP_DRAIN, 8'd0, 0},    '{OP_DRAIN, 8'd255, 0},
         '{OP_DRAIN, 8'd0, 0},    '{OP_DRAIN, 8'd0, 0},
         // next frame, then drains mid-frame
         '{OP_SAMPLE, 8'd255, 0}, '{OP_SAMPLE, 8'd0, 0},
         '{OP_SAMPLE, 8'd255, 0}, '{OP_SAMPLE, 8'd0, 0},
         '{OP_DRAIN, 8'd0, 0},    '{OP_DRAIN, 8'd0, 0}
      };
      foreach (plan[i])
         send_item(plan[i].op, plan[i].hgt, plan[i].flat, plan[i].flat ? flat_normal : none);

      // sender waits for the whole pipe to drain
      while (normal_queue.size() != 0) @(negedge clock);

      // random phases: new image size, then mostly samples with some drains
      items_sent = 0;
      while (items_sent < RAND_ITEMS) begin
         w_pick = $urandom_range(0, 14);
         if (w_pick == 0) write_reg(CSR_IMAGE_WIDTH, w_odd[$urandom_range(0, 5)]);
         else write_reg(CSR_IMAGE_WIDTH, CSR_DATA_W'($urandom_range(1, 12)));
         h_pick = $urandom_range(0, 9);
         if (h_pick == 0) write_reg(CSR_IMAGE_HEIGHT, h_odd[$urandom_range(0, 5)]);
         else write_reg(CSR_IMAGE_HEIGHT, CSR_DATA_W'($urandom_range(1, 5)));
         phase_len = $urandom_range(20, 80);
         for (int i = 0; i < phase_len; i++) begin
            // a stretch of items with no sender gaps
            quiet_send = (items_sent >= 300 && items_sent < 500);
            send_item(($urandom_range(0, 99) < 10) ? OP_DRAIN : OP_SAMPLE,
                      HEIGHT_W'($urandom_range(0, 255)), 1'b0, none);
         end
      end
      quiet_send = 1'b0;

      while (normal_queue.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
      if (errors == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
